[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CVSQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequence holds in the same cycle as the antecedent
`define CVSQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define CVSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/cvsq_pkg.sv]
// ----------------------------------------------------------------------------
// cvsq_pkg
// shared constants of the contour vertex store and query unit
// ----------------------------------------------------------------------------
package cvsq_pkg;

    localparam int MAX_VERTICES_DEF  = 1024;
    localparam int COORD_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int RADIUS_BITS    = 32;
    localparam int INDEX_OUT_BITS = 10;
    localparam int COUNT_OUT_BITS = 11;

    localparam logic [1:0] KIND_APPEND  = 2'd0;
    localparam logic [1:0] KIND_NEAREST = 2'd1;
    localparam logic [1:0] KIND_CONTOUR = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

endpackage

[rtl/cvsq_ram.sv]
// ----------------------------------------------------------------------------
// cvsq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module cvsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/contour_vertex_store_query_unit.sv]
// ----------------------------------------------------------------------------
// contour_vertex_store_query_unit
// append and clear are answered from the done state; queries walk the store
// nearest and contour queries read the stored vertices from the registered-read ram
// and are paced by one shared bit-serial multiply-accumulate unit
// one request at a time; rst_n clears the vertex count and the sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module contour_vertex_store_query_unit #(
    parameter int MAX_VERTICES  = cvsq_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS    = cvsq_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = cvsq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             kind,
    input  logic signed [COORD_BITS-1:0]           x_coord,
    input  logic signed [COORD_BITS-1:0]           y_coord,
    input  logic signed [COORD_BITS-1:0]           z_coord,
    input  logic                                   is_control,
    input  logic signed [cvsq_pkg::RADIUS_BITS-1:0] radius,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   found,
    output logic [cvsq_pkg::INDEX_OUT_BITS-1:0]    vertex_index,
    output logic                                   near_contour,
    output logic                                   rejected,
    output logic [cvsq_pkg::COUNT_OUT_BITS-1:0]    vertex_count
);

    import cvsq_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int SQW  = 2 * DW + 2;
    localparam int EW   = RADIUS_BITS + FRACTION_BITS + 1;
    localparam int OW   = ((SQW > EW) ? SQW : EW) + 1;
    localparam int AW   = 2 * OW + 2;
    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CNTW = $clog2(OW);
    localparam int MW   = 3 * COORD_BITS + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LIM   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_CAP2  = 4'd4;
    localparam logic [3:0] S_GO    = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_STEP  = 4'd7;
    localparam logic [3:0] S_CMP_N = 4'd8;
    localparam logic [3:0] S_CMP_C = 4'd9;
    localparam logic [3:0] S_CMP_B = 4'd10;
    localparam logic [3:0] S_CMP_F = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // product terms; terms of one dot product follow each other
    localparam logic [3:0] T_RR  = 4'd0;
    localparam logic [3:0] T_SS0 = 4'd1;
    localparam logic [3:0] T_SS1 = 4'd2;
    localparam logic [3:0] T_SS2 = 4'd3;
    localparam logic [3:0] T_AS0 = 4'd4;
    localparam logic [3:0] T_AS1 = 4'd5;
    localparam logic [3:0] T_AS2 = 4'd6;
    localparam logic [3:0] T_AA0 = 4'd7;
    localparam logic [3:0] T_AA1 = 4'd8;
    localparam logic [3:0] T_AA2 = 4'd9;
    localparam logic [3:0] T_BB0 = 4'd10;
    localparam logic [3:0] T_BB1 = 4'd11;
    localparam logic [3:0] T_BB2 = 4'd12;
    localparam logic [3:0] T_EL  = 4'd13;
    localparam logic [3:0] T_DD  = 4'd14;
    localparam logic [3:0] T_NL  = 4'd15;

    typedef struct packed {
        logic signed [OW-1:0] opa;
        logic signed [OW-1:0] opb;
        logic [CNTW-1:0]      cnt;
        logic                 clear;
    } mul_op_t;

    // control registers
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [1:0]                    kind_reg, kind_next;
    logic signed [COORD_BITS-1:0]  px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [RADIUS_BITS-1:0] r_reg, r_next;
    logic signed [COORD_BITS-1:0]  v1x_reg, v1x_next, v1y_reg, v1y_next, v1z_reg, v1z_next;
    logic signed [COORD_BITS-1:0]  v2x_reg, v2x_next, v2y_reg, v2y_next, v2z_reg, v2z_next;
    logic                          flag1_reg, flag1_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic signed [SQW-1:0]         l2_reg, l2_next, dt_reg, dt_next, a2_reg, a2_next;
    logic signed [SQW-1:0]         best_reg, best_next;
    logic signed [AW-1:0]          lim_reg, lim_next;
    logic                          have_reg, have_next, have_ctl_reg, have_ctl_next;
    logic [IW-1:0]                 best_i_reg, best_i_next, ctl_i_reg, ctl_i_next;
    logic                          near_reg, near_next, rej_reg, rej_next;
    logic signed [AW-1:0]          acc_reg, acc_next, mul_a_reg, mul_a_next;
    logic signed [OW-1:0]          mul_b_reg, mul_b_next;
    logic [CNTW-1:0]               cnt_reg, cnt_next;
    logic [3:0]                    term_reg, term_next;

    logic                          found_reg, found_next;
    logic [INDEX_OUT_BITS-1:0]     vertex_index_reg, vertex_index_next;
    logic                          near_contour_reg, near_contour_next;
    logic                          rejected_reg, rejected_next;
    logic [COUNT_OUT_BITS-1:0]     vertex_count_reg, vertex_count_next;

    // datapath
    logic signed [DW-1:0] ax, ay, az, sx, sy, sz, bx, by, bz;
    logic signed [EW-1:0] e_val;
    logic signed [AW-1:0] addend;
    logic [CW-1:0]        idx_inc;
    logic                 last_item;
    logic [IW-1:0]        v2_idx, sel_idx;
    logic                 start_en;
    logic [3:0]           start_term;
    mul_op_t              op;

    logic          ram_we;
    logic [IW-1:0] ram_raddr;
    logic [MW-1:0] ram_wdata, ram_rdata;

    assign ax = DW'(px_reg) - DW'(v1x_reg);
    assign ay = DW'(py_reg) - DW'(v1y_reg);
    assign az = DW'(pz_reg) - DW'(v1z_reg);
    assign sx = DW'(v2x_reg) - DW'(v1x_reg);
    assign sy = DW'(v2y_reg) - DW'(v1y_reg);
    assign sz = DW'(v2z_reg) - DW'(v1z_reg);
    assign bx = DW'(px_reg) - DW'(v2x_reg);
    assign by = DW'(py_reg) - DW'(v2y_reg);
    assign bz = DW'(pz_reg) - DW'(v2z_reg);

    // squared tolerance scaled to the squared-coordinate fraction
    assign e_val = $signed({1'b0, r_reg, {FRACTION_BITS{1'b0}}});

    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign last_item = (idx_inc == count_reg);
    assign v2_idx    = last_item ? '0 : idx_inc[IW-1:0];
    assign sel_idx   = have_ctl_reg ? ctl_i_reg : best_i_reg;

    assign ram_wdata = {is_control, z_coord, y_coord, x_coord};

    cvsq_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic mul_op_t term_op(input logic [3:0] t);
        mul_op_t o;
        o.opa   = '0;
        o.opb   = '0;
        o.cnt   = CNTW'(DW - 1);
        o.clear = 1'b0;
        case (t)
            T_RR:  begin o.opa = OW'(r_reg); o.opb = OW'(r_reg);
                         o.cnt = CNTW'(RADIUS_BITS - 1); o.clear = 1'b1; end
            T_SS0: begin o.opa = OW'(sx); o.opb = OW'(sx); o.clear = 1'b1; end
            T_SS1: begin o.opa = OW'(sy); o.opb = OW'(sy); end
            T_SS2: begin o.opa = OW'(sz); o.opb = OW'(sz); end
            T_AS0: begin o.opa = OW'(ax); o.opb = OW'(sx); o.clear = 1'b1; end
            T_AS1: begin o.opa = OW'(ay); o.opb = OW'(sy); end
            T_AS2: begin o.opa = OW'(az); o.opb = OW'(sz); end
            T_AA0: begin o.opa = OW'(ax); o.opb = OW'(ax); o.clear = 1'b1; end
            T_AA1: begin o.opa = OW'(ay); o.opb = OW'(ay); end
            T_AA2: begin o.opa = OW'(az); o.opb = OW'(az); end
            T_BB0: begin o.opa = OW'(bx); o.opb = OW'(bx); o.clear = 1'b1; end
            T_BB1: begin o.opa = OW'(by); o.opb = OW'(by); end
            T_BB2: begin o.opa = OW'(bz); o.opb = OW'(bz); end
            // e*l2 + dt*dt - a2*l2 > 0 replaces the projection divide
            T_EL:  begin o.opa = OW'(e_val); o.opb = OW'(l2_reg);
                         o.cnt = CNTW'(OW - 1); o.clear = 1'b1; end
            T_DD:  begin o.opa = OW'(dt_reg); o.opb = OW'(dt_reg);
                         o.cnt = CNTW'(OW - 1); end
            T_NL:  begin o.opa = -OW'(a2_reg); o.opb = OW'(l2_reg);
                         o.cnt = CNTW'(OW - 1); end
            default: o.cnt = CNTW'(DW - 1);
        endcase
        return o;
    endfunction

    // shift-add step; the sign bit of the multiplier carries negative weight
    always_comb
    begin
        if (mul_b_reg[0])
        begin
            addend = (cnt_reg == '0) ? -mul_a_reg : mul_a_reg;
        end
        else
        begin
            addend = '0;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        out_valid_next    = out_valid_reg;
        kind_next         = kind_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        pz_next           = pz_reg;
        r_next            = r_reg;
        v1x_next          = v1x_reg;
        v1y_next          = v1y_reg;
        v1z_next          = v1z_reg;
        v2x_next          = v2x_reg;
        v2y_next          = v2y_reg;
        v2z_next          = v2z_reg;
        flag1_next        = flag1_reg;
        idx_next          = idx_reg;
        l2_next           = l2_reg;
        dt_next           = dt_reg;
        a2_next           = a2_reg;
        best_next         = best_reg;
        lim_next          = lim_reg;
        have_next         = have_reg;
        have_ctl_next     = have_ctl_reg;
        best_i_next       = best_i_reg;
        ctl_i_next        = ctl_i_reg;
        near_next         = near_reg;
        rej_next          = rej_reg;
        acc_next          = acc_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        cnt_next          = cnt_reg;
        term_next         = term_reg;
        found_next        = found_reg;
        vertex_index_next = vertex_index_reg;
        near_contour_next = near_contour_reg;
        rejected_next     = rejected_reg;
        vertex_count_next = vertex_count_reg;
        ram_we            = 1'b0;
        ram_raddr         = idx_reg;
        start_en          = 1'b0;
        start_term        = T_RR;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = kind;
                    px_next       = x_coord;
                    py_next       = y_coord;
                    pz_next       = z_coord;
                    r_next        = radius;
                    have_next     = 1'b0;
                    have_ctl_next = 1'b0;
                    best_i_next   = '0;
                    ctl_i_next    = '0;
                    near_next     = 1'b0;
                    rej_next      = 1'b0;
                    idx_next      = '0;
                    state_next    = S_DONE;
                    case (kind)
                        KIND_APPEND:
                        begin
                            if (count_reg >= CW'(MAX_VERTICES))
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_NEAREST:
                        begin
                            if (!(radius[RADIUS_BITS-1] || radius == '0 || count_reg == '0))
                            begin
                                state_next = S_LIM;
                            end
                        end
                        KIND_CONTOUR:
                        begin
                            if (!(radius[RADIUS_BITS-1] || radius == '0 || count_reg == '0))
                            begin
                                state_next = S_RD1;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_LIM:
            begin
                start_en   = 1'b1;
                start_term = T_RR;
            end
            S_RD1:
            begin
                ram_raddr  = idx_reg;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                v1x_next   = ram_rdata[COORD_BITS-1:0];
                v1y_next   = ram_rdata[2*COORD_BITS-1:COORD_BITS];
                v1z_next   = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
                flag1_next = ram_rdata[MW-1];
                ram_raddr  = v2_idx;
                state_next = S_CAP2;
            end
            S_CAP2:
            begin
                v2x_next   = ram_rdata[COORD_BITS-1:0];
                v2y_next   = ram_rdata[2*COORD_BITS-1:COORD_BITS];
                v2z_next   = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
                state_next = S_GO;
            end
            S_GO:
            begin
                start_en   = 1'b1;
                start_term = (kind_reg == KIND_NEAREST) ? T_AA0 : T_SS0;
            end
            S_MUL:
            begin
                acc_next   = acc_reg + addend;
                mul_a_next = mul_a_reg <<< 1;
                mul_b_next = mul_b_reg >>> 1;
                cnt_next   = cnt_reg - CNTW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                case (term_reg)
                    T_RR:
                    begin
                        lim_next   = acc_reg;
                        state_next = S_RD1;
                    end
                    T_SS2:
                    begin
                        l2_next    = $signed(acc_reg[SQW-1:0]);
                        start_en   = 1'b1;
                        start_term = T_AS0;
                    end
                    T_AS2:
                    begin
                        dt_next    = $signed(acc_reg[SQW-1:0]);
                        start_en   = 1'b1;
                        start_term = T_AA0;
                    end
                    T_AA2:
                    begin
                        a2_next    = $signed(acc_reg[SQW-1:0]);
                        state_next = (kind_reg == KIND_NEAREST) ? S_CMP_N : S_CMP_C;
                    end
                    T_BB2:
                    begin
                        state_next = S_CMP_B;
                    end
                    T_NL:
                    begin
                        state_next = S_CMP_F;
                    end
                    default:
                    begin
                        start_en   = 1'b1;
                        start_term = term_reg + 4'd1;
                    end
                endcase
            end
            S_CMP_N:
            begin
                // strict improvement inside the radius
                if (AW'(a2_reg) < lim_reg && (!have_reg || a2_reg < best_reg))
                begin
                    have_next   = 1'b1;
                    best_next   = a2_reg;
                    best_i_next = idx_reg;
                    if (flag1_reg)
                    begin
                        have_ctl_next = 1'b1;
                        ctl_i_next    = idx_reg;
                    end
                end
                if (last_item)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc[IW-1:0];
                    state_next = S_RD1;
                end
            end
            S_CMP_C:
            begin
                if (l2_reg[SQW-1] || l2_reg == '0 || dt_reg[SQW-1] || dt_reg == '0)
                begin
                    // projection before the first end or degenerate segment
                    if (AW'(a2_reg) < AW'(e_val))
                    begin
                        near_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (last_item)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc[IW-1:0];
                        state_next = S_RD1;
                    end
                end
                else if (l2_reg <= dt_reg)
                begin
                    start_en   = 1'b1;
                    start_term = T_BB0;
                end
                else
                begin
                    start_en   = 1'b1;
                    start_term = T_EL;
                end
            end
            S_CMP_B, S_CMP_F:
            begin
                if ((state_reg == S_CMP_B) ? (acc_reg < AW'(e_val))
                                           : (!acc_reg[AW-1] && acc_reg != '0))
                begin
                    near_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (last_item)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc[IW-1:0];
                    state_next = S_RD1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    found_next        = (kind_reg == KIND_NEAREST) && have_reg;
                    vertex_index_next = ((kind_reg == KIND_NEAREST) && have_reg)
                                        ? INDEX_OUT_BITS'(sel_idx) : '0;
                    near_contour_next = (kind_reg == KIND_CONTOUR) && near_reg;
                    rejected_next     = (kind_reg == KIND_APPEND) && rej_reg;
                    vertex_count_next = COUNT_OUT_BITS'(count_reg);
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start_en)
        begin
            op         = term_op(start_term);
            mul_a_next = AW'(op.opa);
            mul_b_next = op.opb;
            cnt_next   = op.cnt;
            term_next  = start_term;
            if (op.clear)
            begin
                acc_next = '0;
            end
            state_next = S_MUL;
        end
        else
        begin
            op = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        px_reg           <= px_next;
        py_reg           <= py_next;
        pz_reg           <= pz_next;
        r_reg            <= r_next;
        v1x_reg          <= v1x_next;
        v1y_reg          <= v1y_next;
        v1z_reg          <= v1z_next;
        v2x_reg          <= v2x_next;
        v2y_reg          <= v2y_next;
        v2z_reg          <= v2z_next;
        flag1_reg        <= flag1_next;
        idx_reg          <= idx_next;
        l2_reg           <= l2_next;
        dt_reg           <= dt_next;
        a2_reg           <= a2_next;
        best_reg         <= best_next;
        lim_reg          <= lim_next;
        have_reg         <= have_next;
        have_ctl_reg     <= have_ctl_next;
        best_i_reg       <= best_i_next;
        ctl_i_reg        <= ctl_i_next;
        near_reg         <= near_next;
        rej_reg          <= rej_next;
        acc_reg          <= acc_next;
        mul_a_reg        <= mul_a_next;
        mul_b_reg        <= mul_b_next;
        cnt_reg          <= cnt_next;
        term_reg         <= term_next;
        found_reg        <= found_next;
        vertex_index_reg <= vertex_index_next;
        near_contour_reg <= near_contour_next;
        rejected_reg     <= rejected_next;
        vertex_count_reg <= vertex_count_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign vertex_index = vertex_index_reg;
    assign near_contour = near_contour_reg;
    assign rejected     = rejected_reg;
    assign vertex_count = vertex_count_reg;

    `CVSQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_VERTICES))
    `CVSQ_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_reg != S_IDLE)
    `CVSQ_ASSERT_IMPLIES(a_index_stored, state_reg == S_DONE && kind_reg == KIND_NEAREST && have_reg, CW'(sel_idx) < count_reg)
    `CVSQ_ASSERT_ALWAYS(a_one_answer, !(out_valid_reg && found_reg && near_contour_reg))

endmodule
